>>> sv/ffba_pkg.sv
`default_nettype none
package ffba_pkg;
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_ARD, S_GROW, S_SPLIT_SH, S_SPLIT_WR,
        S_FSCAN, S_FRD, S_FNEXT, S_FPREV, S_RM, S_DONE
    } t_state;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_OOM     = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_DOUBLE  = 3'd4;
endpackage
`default_nettype wire

>>> sv/first_fit_block_allocator.sv
// One request is handled at a time.
// Worst case is a free that merges with both neighbors in a full table: the scan and two
// entry shifts each step one table entry per cycle through the table's single read port.
// o_s_tready is low while busy, until the result has been taken by i_m_tready.
// Reset (synchronous, active low) restores one free block spanning the initial arena
// and the register reset values; table entries beyond the first are not cleared.
`default_nettype none
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS    = 64,
    parameter int HEADER_BYTES  = 20,
    parameter int PAGE_BYTES    = 4096,
    parameter int INITIAL_BYTES = 4194304
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // [29:0] request_bytes, [61:30] free_address, [63:62] zero
    input  wire  [63:0] i_s_tdata,
    // [0] op
    input  wire         i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [31:0] granted_address, [34:32] status, [39:35] zero
    output logic [39:0] o_m_tdata,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import ffba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 61;
    localparam longint G0 = ((longint'(INITIAL_BYTES) + HEADER_BYTES + PAGE_BYTES - 1)
                             / PAGE_BYTES) * PAGE_BYTES;
    localparam logic [29:0] G_INIT = 30'(G0);
    localparam logic [29:0] P_INIT = 30'(G0 - HEADER_BYTES);
    localparam logic [29:0] HDR = 30'(HEADER_BYTES);
    localparam int PB = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

    // memory entry: {free, size, offset}
    logic [EW-1:0] r_mem [MAX_BLOCKS];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;
    // entry 0 shadow after reset
    logic          r_v0;

    t_state r_state, n_state;
    logic [31:0] r_base;
    logic [29:0] r_limit;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [29:0] r_end, n_end;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_k, n_k;
    logic [31:0] r_size, n_size;
    logic [31:0] r_addr;
    logic        r_op;
    logic [EW-1:0] r_e, n_e;
    logic [31:0] r_gout, n_gout;
    logic [2:0]  r_st, n_st;
    logic        r_ov, n_ov;
    logic [IW-1:0] mem_ra_q;

    wire [EW-1:0] rd0 = {1'b1, P_INIT, 30'd0};
    wire [EW-1:0] rdv = (r_v0 && mem_ra_q == '0) ? rd0 : r_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
        mem_ra_q <= mem_ra;
    end

    wire acc_in = i_s_tvalid && o_s_tready;
    wire [29:0] e_off = rdv[29:0];
    wire [29:0] e_sz  = rdv[59:30];
    wire        e_fr  = rdv[60];
    wire [31:0] paddr_e = r_base + {2'b0, e_off} + 32'(HEADER_BYTES);
    wire [32:0] grow_raw = {1'b0, r_size} + 33'(2 * HEADER_BYTES) + 33'(PAGE_BYTES - 1);
    wire [32:0] growth = {grow_raw[32:PB], {PB{1'b0}}};
    wire [IW:0] cntm1 = r_cnt - 1'b1;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_end = r_end; n_i = r_i; n_k = r_k;
        n_size = r_size; n_e = r_e;
        n_gout = r_gout; n_st = r_st; n_ov = r_ov;
        mem_we = 1'b0; mem_wa = r_k; mem_wd = r_e; mem_ra = r_i;
        unique case (r_state)
            S_IDLE: begin
                mem_ra = '0;
                if (acc_in) begin
                    n_i = '0; n_gout = '0; n_st = ST_OK;
                    n_size = {2'b0, i_s_tdata[29:0]} + 32'd3;
                    n_size[1:0] = 2'b0;
                    if (!i_s_tuser) begin
                        if (i_s_tdata[29:0] == '0) begin
                            n_st = ST_ZERO; n_state = S_DONE;
                        end else n_state = S_SCAN;
                    end else begin
                        if (i_s_tdata[61:30] == '0) begin
                            n_st = ST_ZERO; n_state = S_DONE;
                        end else n_state = S_FSCAN;
                    end
                end
            end
            S_SCAN: begin
                // rdv holds entry r_i
                if (e_fr && {2'b0, e_sz} >= r_size) begin
                    n_e = rdv; n_state = S_ARD;
                end else if ({1'b0, r_i} == cntm1) begin
                    if (r_cnt >= CMAX ||
                        {4'b0, r_end} + {1'b0, growth} > {4'b0, r_limit}) begin
                        n_st = ST_OOM; n_state = S_DONE;
                    end else n_state = S_GROW;
                end else begin
                    n_i = r_i + 1'b1; mem_ra = n_i; n_state = S_SCAN;
                end
                if (n_state == S_SCAN) mem_ra = r_i + 1'b1;
            end
            S_GROW: begin
                n_i = IW'(r_cnt);
                n_e = {1'b1, 30'(growth) - HDR, r_end};
                n_cnt = r_cnt + 1'b1;
                n_end = r_end + 30'(growth);
                mem_we = 1'b1; mem_wa = IW'(r_cnt); mem_wd = n_e;
                n_state = S_ARD;
            end
            S_ARD: begin
                // grant entry r_e at index r_i
                n_gout = r_base + {2'b0, r_e[29:0]} + 32'(HEADER_BYTES);
                if ({2'b0, r_e[59:30]} > r_size + 32'(HEADER_BYTES) && r_cnt < CMAX) begin
                    n_k = IW'(r_cnt); mem_ra = IW'(r_cnt - 1'b1);
                    n_state = ({1'b0, r_i} + 1'b1 == r_cnt) ? S_SPLIT_WR : S_SPLIT_SH;
                    if (n_state == S_SPLIT_SH) n_k = IW'(r_cnt);
                end else begin
                    mem_we = 1'b1; mem_wa = r_i; mem_wd = {1'b0, r_e[59:0]};
                    n_state = S_DONE;
                end
            end
            S_SPLIT_SH: begin
                // rdv = entry r_k-1; write to r_k
                mem_we = 1'b1; mem_wa = r_k; mem_wd = rdv;
                n_k = r_k - 1'b1;
                mem_ra = r_k - 2'd2;
                if (r_k - 1'b1 == r_i + 1'b1) n_state = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                if (!r_ov) begin
                    mem_we = 1'b1; mem_wa = r_i + 1'b1;
                    mem_wd = {1'b1, r_e[59:30] - r_size[29:0] - HDR,
                              r_e[29:0] + HDR + r_size[29:0]};
                    n_ov = 1'b1;
                end else begin
                    mem_we = 1'b1; mem_wa = r_i;
                    mem_wd = {1'b0, r_size[29:0], r_e[29:0]};
                    n_cnt = r_cnt + 1'b1; n_ov = 1'b0; n_state = S_DONE;
                end
            end
            S_FSCAN: begin
                if (paddr_e == r_addr) begin
                    if (e_fr) begin
                        n_st = ST_DOUBLE; n_state = S_DONE;
                    end else begin
                        n_e = {1'b1, rdv[59:0]};
                        mem_ra = r_i + 1'b1;
                        n_state = S_FNEXT;
                        if ({1'b0, r_i} + 1'b1 == r_cnt) n_state = S_FRD;
                    end
                end else if ({1'b0, r_i} == cntm1) begin
                    n_st = ST_INVALID; n_state = S_DONE;
                end else begin
                    n_i = r_i + 1'b1; mem_ra = r_i + 1'b1;
                end
            end
            S_FNEXT: begin
                if (e_fr) begin
                    n_e[59:30] = r_e[59:30] + HDR + e_sz;
                    n_k = r_i + 1'b1; mem_ra = r_i + 2'd2;
                    n_cnt = r_cnt - 1'b1;
                    n_state = S_RM; n_ov = 1'b0;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_RM: begin
                // shift entries above r_k down by one
                if ({1'b0, r_k} >= r_cnt) begin
                    n_state = r_ov ? S_DONE : S_FRD;
                end else begin
                    mem_we = 1'b1; mem_wa = r_k; mem_wd = rdv;
                    n_k = r_k + 1'b1; mem_ra = r_k + 2'd2;
                end
            end
            S_FRD: begin
                // write merged block; then look at previous
                mem_we = 1'b1; mem_wa = r_i; mem_wd = r_e;
                mem_ra = r_i - 1'b1;
                n_state = (r_i != '0) ? S_FPREV : S_DONE;
                if (r_ov) n_state = S_DONE;
            end
            S_FPREV: begin
                if (e_fr) begin
                    mem_we = 1'b1; mem_wa = r_i - 1'b1;
                    mem_wd = {1'b1, e_sz + HDR + r_e[59:30], e_off};
                    n_k = r_i; mem_ra = r_i + 1'b1;
                    n_cnt = r_cnt - 1'b1; n_ov = 1'b1; n_state = S_RM;
                end else n_state = S_DONE;
            end
            S_DONE: begin
                n_ov = 1'b0;
                if (i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= CW'(1); r_end <= G_INIT;
            r_base <= 32'hD000_0000; r_limit <= 30'd268435456;
            r_v0 <= 1'b1; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_end <= n_end; r_ov <= n_ov;
            if (mem_we && mem_wa == '0) r_v0 <= 1'b0;
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr[2] == 1'b0) r_base <= i_pwdata;
                else r_limit <= i_pwdata[29:0];
            end
        end
        r_i <= n_i; r_k <= n_k; r_size <= n_size; r_e <= n_e;
        r_gout <= n_gout; r_st <= n_st;
        if (acc_in) begin
            r_op <= i_s_tuser; r_addr <= i_s_tdata[61:30];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_DONE);
    assign o_m_tdata  = {5'b0, r_st, (r_st == ST_OK && !r_op) ? r_gout : 32'd0};
    assign o_prdata   = i_paddr[2] ? {2'b0, r_limit} : r_base;
    assign o_pready   = 1'b1;

`ifndef SYNTH
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 && r_cnt <= CMAX) else $error("block count out of range");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata)) else $error("result changed");
`endif
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ffba_pkg::*;

    localparam int MAX_BLOCKS    = 64;
    localparam int HEADER_BYTES  = 20;
    localparam int PAGE_BYTES    = 4096;
    localparam int INITIAL_BYTES = 4194304;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic [2:0] REG_HEAP_BASE   = 3'd0;
    localparam logic [2:0] REG_ARENA_LIMIT = 3'd4;
    localparam int WATCHDOG_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    first_fit_block_allocator dut (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  status;
    } t_grant;

    // allocator mirror
    logic [31:0] heap_base;
    logic [29:0] arena_limit;
    logic [29:0] blk_off [MAX_BLOCKS];
    logic [29:0] blk_size[MAX_BLOCKS];
    logic        blk_free[MAX_BLOCKS];
    int          blk_count;
    logic [29:0] arena_end;

    t_grant      pending_grants[$];
    logic [31:0] live_ptrs[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    function automatic logic [63:0] page_round(logic [63:0] x);
        return ((x + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    function automatic logic [31:0] payload_of(int i);
        return heap_base + 32'(blk_off[i]) + HEADER_BYTES;
    endfunction

    task automatic mirror_reset();
        logic [63:0] g;
        g = page_round(INITIAL_BYTES + HEADER_BYTES);
        heap_base = 32'hD000_0000;
        arena_limit = 30'd268435456;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            blk_off[k] = '0;
            blk_size[k] = '0;
            blk_free[k] = 1'b0;
        end
        blk_size[0] = 30'(g - HEADER_BYTES);
        blk_free[0] = 1'b1;
        blk_count = 1;
        arena_end = 30'(g);
    endtask

    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < blk_count; k++) begin
            blk_off[k] = blk_off[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_count--;
    endfunction

    function automatic void take_block(int i, logic [63:0] sz);
        if (64'(blk_size[i]) > sz + HEADER_BYTES && blk_count < MAX_BLOCKS) begin
            for (int k = blk_count; k > i + 1; k--) begin
                blk_off[k] = blk_off[k-1];
                blk_size[k] = blk_size[k-1];
                blk_free[k] = blk_free[k-1];
            end
            blk_off[i+1] = 30'(64'(blk_off[i]) + HEADER_BYTES + sz);
            blk_size[i+1] = 30'(64'(blk_size[i]) - sz - HEADER_BYTES);
            blk_free[i+1] = 1'b1;
            blk_size[i] = 30'(sz);
            blk_count++;
        end
        blk_free[i] = 1'b0;
    endfunction

    function automatic t_grant predict_alloc(logic [29:0] bytes);
        t_grant r;
        logic [63:0] sz, growth;
        int i;
        r = '0;
        if (bytes == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        sz = (64'(bytes) + 3) & ~64'd3;
        for (i = 0; i < blk_count; i++) begin
            if (blk_free[i] && 64'(blk_size[i]) >= sz) begin
                take_block(i, sz);
                r.addr = payload_of(i);
                return r;
            end
        end
        growth = page_round(sz + 2 * HEADER_BYTES);
        if (blk_count >= MAX_BLOCKS || 64'(arena_end) + growth > 64'(arena_limit)) begin
            r.status = ST_OOM;
            return r;
        end
        i = blk_count;
        blk_off[i] = arena_end;
        blk_size[i] = 30'(growth - HEADER_BYTES);
        blk_free[i] = 1'b1;
        blk_count++;
        arena_end = 30'(64'(arena_end) + growth);
        take_block(i, sz);
        r.addr = payload_of(i);
        return r;
    endfunction

    function automatic t_grant predict_free(logic [31:0] addr);
        t_grant r;
        int i;
        r = '0;
        if (addr == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        for (i = 0; i < blk_count; i++)
            if (payload_of(i) == addr) break;
        if (i >= blk_count) begin
            r.status = ST_INVALID;
            return r;
        end
        if (blk_free[i]) begin
            r.status = ST_DOUBLE;
            return r;
        end
        blk_free[i] = 1'b1;
        if (i + 1 < blk_count && blk_free[i+1]) begin
            blk_size[i] = 30'(64'(blk_size[i]) + HEADER_BYTES + blk_size[i+1]);
            drop_entry(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
            blk_size[i-1] = 30'(64'(blk_size[i-1]) + HEADER_BYTES + blk_size[i]);
            drop_entry(i);
        end
        return r;
    endfunction

    task automatic apb_write(logic [2:0] a, logic [31:0] d);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= a;
        i_pwdata <= d;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        if (a == REG_HEAP_BASE) heap_base = d;
        else arena_limit = d[29:0];
    endtask

    // one request: idle gap, handshake, predict
    task automatic send_req(logic op, logic [29:0] bytes, logic [31:0] addr,
                            logic chk, t_grant fixed);
        t_grant p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {2'b00, addr, bytes};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        p = (op == OP_ALLOC) ? predict_alloc(bytes) : predict_free(addr);
        if (chk && p != fixed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row: exp addr %h st %0d, predicted addr %h st %0d",
                         fixed.addr, fixed.status, p.addr, p.status);
        end
        if (op == OP_ALLOC && p.status == ST_OK) live_ptrs.push_back(p.addr);
        pending_grants.push_back(p);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (3 * MAX_BLOCKS + 20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_m_tdata);
                end else begin
                    t_grant e;
                    e = pending_grants.pop_front();
                    if (o_m_tdata[31:0] !== e.addr || o_m_tdata[34:32] !== e.status
                        || o_m_tdata[39:35] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp addr %h st %0d, got addr %h st %0d",
                                     e.addr, e.status, o_m_tdata[31:0], o_m_tdata[34:32]);
                    end
                end
            end
        end
    end

    typedef struct {
        logic        op;
        logic [29:0] bytes;
        logic [31:0] addr;
        logic        chk;
        t_grant      fixed;
    } t_row;

    t_row rows[$];

    task automatic random_phase(int n, logic [31:0] base, logic [29:0] lim);
        int idx;
        logic [29:0] b;
        logic [31:0] a;
        apb_write(REG_HEAP_BASE, base);
        apb_write(REG_ARENA_LIMIT, {2'b00, lim});
        live_ptrs.delete();
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    b = (live_ptrs.size() > 40) ? 30'($urandom_range(1, 64))
                        : ($urandom_range(7) == 0) ? 30'($urandom_range(1, 20000))
                        : 30'($urandom_range(1, 300));
                    send_req(OP_ALLOC, b, 32'($urandom), 1'b0, '0);
                end
                4: send_req(OP_ALLOC, ($urandom_range(3) == 0) ? 30'($urandom) : 30'd0,
                            32'($urandom), 1'b0, '0);
                5, 6, 7: begin
                    if (live_ptrs.size() != 0) begin
                        idx = $urandom_range(live_ptrs.size() - 1);
                        a = live_ptrs[idx];
                        live_ptrs.delete(idx);
                    end else a = 32'($urandom);
                    send_req(OP_FREE, 30'($urandom), a, 1'b0, '0);
                end
                8: send_req(OP_FREE, 30'($urandom),
                            (live_ptrs.size() != 0) ? live_ptrs[0] + 4 : 32'($urandom),
                            1'b0, '0);
                default: send_req(OP_FREE, 30'($urandom),
                                  ($urandom_range(1)) ? 32'd0 : 32'($urandom), 1'b0, '0);
            endcase
        end
        // release what is left so the heap coalesces back
        while (live_ptrs.size() != 0)
            send_req(OP_FREE, 30'd0, live_ptrs.pop_front(), 1'b0, '0);
        drain();
    endtask

    initial begin
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 28;
        recv_idle_pct = 87;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = OP_ALLOC;
        i_m_tready = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        mirror_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{OP_ALLOC, 30'd0,          32'd0, 1'b1, '{32'd0, ST_ZERO}},
            '{OP_ALLOC, 30'd1,          32'd0, 1'b1, '{32'hD000_0014, ST_OK}},
            '{OP_ALLOC, 30'd4,          32'd0, 1'b1, '{32'hD000_002C, ST_OK}},
            '{OP_FREE,  30'd0,          32'd0, 1'b1, '{32'd0, ST_ZERO}},
            '{OP_FREE,  30'd0,  32'hFFFF_FFFF, 1'b1, '{32'd0, ST_INVALID}},
            '{OP_FREE,  30'd0,  32'hD000_0014, 1'b1, '{32'd0, ST_OK}},
            '{OP_FREE,  30'd0,  32'hD000_0014, 1'b1, '{32'd0, ST_DOUBLE}},
            '{OP_ALLOC, 30'h3FFF_FFFF,  32'd0, 1'b1, '{32'd0, ST_OOM}},
            '{OP_ALLOC, 30'd805306368,  32'd0, 1'b1, '{32'd0, ST_OOM}},
            '{OP_ALLOC, 30'd4194304,    32'd0, 1'b0, '0},
            '{OP_ALLOC, 30'd13,         32'd0, 1'b0, '0},
            '{OP_FREE,  30'd0,  32'hD000_002C, 1'b0, '0},
            '{OP_FREE,  30'd0,  32'hD000_0040, 1'b0, '0},
            '{OP_ALLOC, 30'd3,          32'd0, 1'b0, '0}
        };
        foreach (rows[r])
            send_req(rows[r].op, rows[r].bytes, rows[r].addr, rows[r].chk, rows[r].fixed);
        drain();

        // table fill: many large blocks, then small ones, until splits and growth stop
        apb_write(REG_ARENA_LIMIT, 32'h3000_0000);
        for (int k = 0; k < 70; k++)
            send_req(OP_ALLOC, 30'd4194000, 32'($urandom), 1'b0, '0);
        for (int k = 0; k < 8; k++) send_req(OP_ALLOC, 30'd8, 32'd0, 1'b0, '0);
        drain();
        // limit at zero: every growth fails
        apb_write(REG_ARENA_LIMIT, 32'd0);
        send_req(OP_ALLOC, 30'h3FFF_FFFC, 32'd0, 1'b0, '0);
        drain();
        // start fresh: free everything known by walking the mirror
        for (int k = blk_count - 1; k >= 0; k--)
            if (!blk_free[k]) send_req(OP_FREE, 30'd0, payload_of(k), 1'b0, '0);
        drain();

        random_phase(700, 32'hFFFF_FFF0, 30'd268435456);
        send_idle_pct = 87;
        recv_idle_pct = 28;
        random_phase(650, 32'($urandom), 30'd4300000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(650, 32'h0000_0000, 30'h3FFF_FFFF);

        if (pending_grants.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
sv/ffba_pkg.sv
sv/first_fit_block_allocator.sv
tb/tb.sv
